[hdl/wrxdd_pkg.sv]
`default_nettype none

package wrxdd_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] SEQ_UNKNOWN = 16'hffff;
  localparam logic [4:0] MAX_FRAGMENTS = 5'd16;

  typedef enum logic [2:0] {
    ACT_SINGLE       = 3'd0,
    ACT_REASSEMBLED  = 3'd1,
    ACT_HELD         = 3'd2,
    ACT_DUPLICATE    = 3'd3,
    ACT_OUT_OF_ORDER = 3'd4,
    ACT_TABLE_FULL   = 3'd5
  } action_e;

  typedef struct packed {
    logic [47:0] addr;
    logic        keyed_qos;
    logic [3:0]  tid;
    logic        dest_group;
    logic [15:0] seq_ctrl;
    logic        retry;
    logic        more;
  } item_t;

endpackage

`default_nettype wire

[hdl/wlan_rx_dedup_defrag_filter_core.sv]
// Receive duplicate filter and fragment tracker for 802.11 frame headers.
// Request channel: drive the header fields with start_i high; the request is
// taken at a rising edge where busy_o is low. A two-entry queue stores
// classified requests, so busy_o rises only when two requests wait.
// Result channel: result_valid_o is high for exactly one cycle per request,
// with action_o, entry_index_o and fragment_count_o valid in that cycle.
// The receiver cannot stall; results must be taken when shown.
// An accepted request passes through the queue, the table lookup in S_IDLE
// and the entry update in S_UPDATE before its result strobe. The back end
// takes a new request only after the entry update of the last one is done.
// Results come out in request order, one per request.
// Reset (rst_ni low, asynchronous) empties the queue and clears all
// per-originator entry valid bits; the block accepts requests right after.
`default_nettype none

module wlan_rx_dedup_defrag_filter_core
  import wrxdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [47:0] source_address_i,
  input  wire logic        source_is_group_i,
  input  wire logic        dest_is_group_i,
  input  wire logic        is_qos_data_i,
  input  wire logic [3:0]  traffic_id_i,
  input  wire logic [15:0] sequence_control_i,
  input  wire logic        retry_flag_i,
  input  wire logic        more_fragments_i,
  output logic             result_valid_o,
  output logic [2:0]       action_o,
  output logic [3:0]       entry_index_o,
  output logic [4:0]       fragment_count_o
);

  logic  item_valid;
  item_t item;
  logic  item_pop;

  wrxdd_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .source_address_i   (source_address_i),
    .source_is_group_i  (source_is_group_i),
    .dest_is_group_i    (dest_is_group_i),
    .is_qos_data_i      (is_qos_data_i),
    .traffic_id_i       (traffic_id_i),
    .sequence_control_i (sequence_control_i),
    .retry_flag_i       (retry_flag_i),
    .more_fragments_i   (more_fragments_i),
    .item_valid_o       (item_valid),
    .item_o             (item),
    .item_pop_i         (item_pop)
  );

  wrxdd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .item_pop_o       (item_pop),
    .result_valid_o   (result_valid_o),
    .action_o         (action_o),
    .entry_index_o    (entry_index_o),
    .fragment_count_o (fragment_count_o)
  );

endmodule

`default_nettype wire

[hdl/wrxdd_front.sv]
`default_nettype none

module wrxdd_front
  import wrxdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [47:0] source_address_i,
  input  wire logic        source_is_group_i,
  input  wire logic        dest_is_group_i,
  input  wire logic        is_qos_data_i,
  input  wire logic [3:0]  traffic_id_i,
  input  wire logic [15:0] sequence_control_i,
  input  wire logic        retry_flag_i,
  input  wire logic        more_fragments_i,
  output logic             item_valid_o,
  output item_t            item_o,
  input  wire logic        item_pop_i
);

  item_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                push;
  logic                pop;
  item_t               req;

  // classify: key by address always, and by TID only for unicast-source QoS data
  always_comb begin
    req.addr       = source_address_i;
    req.keyed_qos  = is_qos_data_i & ~source_is_group_i;
    req.tid        = (is_qos_data_i & ~source_is_group_i) ? traffic_id_i : 4'd0;
    req.dest_group = dest_is_group_i;
    req.seq_ctrl   = sequence_control_i;
    req.retry      = retry_flag_i;
    req.more       = more_fragments_i;
  end

  assign busy_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push         = start_i & ~busy_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i & item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= req;
    end
  end

endmodule

`default_nettype wire

[hdl/wrxdd_back.sv]
`default_nettype none

module wrxdd_back
  import wrxdd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  output logic       item_pop_o,
  output logic       result_valid_o,
  output logic [2:0] action_o,
  output logic [3:0] entry_index_o,
  output logic [4:0] fragment_count_o
);

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e             state_q;
  item_t              cur_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               hit_q;
  logic               full_q;

  logic               valid_q   [TABLE_ENTRIES];
  logic [47:0]        addr_q    [TABLE_ENTRIES];
  logic [3:0]         tid_q     [TABLE_ENTRIES];
  logic               qos_q     [TABLE_ENTRIES];
  logic [15:0]        seq_q     [TABLE_ENTRIES];
  logic               known_q   [TABLE_ENTRIES];
  logic               reasm_q   [TABLE_ENTRIES];
  logic [4:0]         held_q    [TABLE_ENTRIES];

  logic               hit;
  logic               free_found;
  logic [SLOT_W-1:0]  hit_slot;
  logic [SLOT_W-1:0]  free_slot;

  logic [15:0]        last_seq;
  logic               last_known;
  logic               reasm;
  logic [4:0]         held;
  logic               in_order;
  logic               rec;
  logic               reasm_n;
  logic [4:0]         held_n;
  action_e            act;
  logic [4:0]         cnt;
  logic [SLOT_W+3:0]  slot_ext;

  // lookup: lowest matching entry, lowest free entry
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    hit_slot   = '0;
    free_slot  = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && addr_q[i] == item_i.addr && qos_q[i] == item_i.keyed_qos &&
          tid_q[i] == item_i.tid) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;

  // update
  always_comb begin
    last_seq   = hit_q ? seq_q[slot_q]   : SEQ_UNKNOWN;
    last_known = hit_q ? known_q[slot_q] : 1'b0;
    reasm      = hit_q ? reasm_q[slot_q] : 1'b0;
    held       = hit_q ? held_q[slot_q]  : 5'd0;
    in_order   = (cur_q.seq_ctrl[15:4] == last_seq[15:4]) &&
                 ({1'b0, cur_q.seq_ctrl[3:0]} == {1'b0, last_seq[3:0]} + 5'd1);
    rec        = 1'b0;
    reasm_n    = reasm;
    held_n     = held;
    act        = ACT_SINGLE;
    cnt        = 5'd1;
    if (full_q) begin
      act = ACT_TABLE_FULL;
      cnt = cur_q.more ? 5'd0 : 5'd1;
    end else if (cur_q.retry && last_known && last_seq == cur_q.seq_ctrl) begin
      act = ACT_DUPLICATE;
      cnt = held;
    end else if (reasm) begin
      if (!in_order) begin
        act = ACT_OUT_OF_ORDER;
        cnt = held;
      end else if (cur_q.more) begin
        held_n = (held < MAX_FRAGMENTS) ? held + 5'd1 : held;
        rec    = 1'b1;
        act    = ACT_HELD;
        cnt    = held_n;
      end else begin
        reasm_n = 1'b0;
        held_n  = 5'd0;
        rec     = 1'b1;
        act     = ACT_REASSEMBLED;
        cnt     = (held < MAX_FRAGMENTS) ? held + 5'd1 : MAX_FRAGMENTS;
      end
    end else if (cur_q.more) begin
      reasm_n = 1'b1;
      held_n  = 5'd1;
      rec     = 1'b1;
      act     = ACT_HELD;
      cnt     = 5'd1;
    end else begin
      rec = ~cur_q.dest_group;
    end
  end

  assign slot_ext = {4'd0, (full_q ? {SLOT_W{1'b0}} : slot_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      hit_q            <= 1'b0;
      full_q           <= 1'b0;
      slot_q           <= '0;
      result_valid_o   <= 1'b0;
      action_o         <= 3'd0;
      entry_index_o    <= 4'd0;
      fragment_count_o <= 5'd0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            hit_q   <= hit;
            full_q  <= ~hit & ~free_found;
            slot_q  <= hit ? hit_slot : free_slot;
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          result_valid_o   <= 1'b1;
          action_o         <= act;
          entry_index_o    <= slot_ext[3:0];
          fragment_count_o <= cnt;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) begin
      cur_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (state_q == S_UPDATE && !full_q) begin
      valid_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPDATE && !full_q) begin
      addr_q[slot_q]  <= cur_q.addr;
      tid_q[slot_q]   <= cur_q.tid;
      qos_q[slot_q]   <= cur_q.keyed_qos;
      reasm_q[slot_q] <= reasm_n;
      held_q[slot_q]  <= held_n;
      seq_q[slot_q]   <= rec ? cur_q.seq_ctrl : last_seq;
      known_q[slot_q] <= rec | last_known;
    end
  end

endmodule

`default_nettype wire
